// ===== rtl/pbc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pbc_pkg
// Shared types and constants of the page buffer cache policy block.
// ---------------------------------------------------------------------------
package pbc_pkg;

	localparam int NUM_SLOTS   = 32;
	localparam int MAX_RESULTS = 32;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);
	localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
	localparam logic [7:0] LOCK_MAX = 8'hFF;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_NEW    = 3'd1,
		OP_REL    = 3'd2,
		OP_FAIL   = 3'd3,
		OP_ZAP    = 3'd4,
		OP_FLUSHE = 3'd5,
		OP_FLUSHA = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT    = 3'd0,
		ST_MISS   = 3'd1,
		ST_NEW    = 3'd2,
		ST_LOCKED = 3'd3,
		ST_FLUSH  = 3'd4,
		ST_DONE   = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] fid_volume;
		logic [31:0] fid_vnode;
		logic [31:0] fid_unique;
		logic [15:0] page;
		logic [4:0]  slot;
		logic        modified;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  slot_out;
		logic        writeback;
		logic [31:0] wb_volume;
		logic [31:0] wb_vnode;
		logic [31:0] wb_unique;
		logic [15:0] wb_page;
		logic        last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_clr;
		logic ptr_clr;
		logic scan_step;
		logic do_hit;
		logic do_alloc;
		logic do_simple;
		logic do_flush;
	} pbc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic hit_found;
		logic flush_hit;
		logic flush_none;
		logic flush_last;
	} pbc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/pbc_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pbc_datapath
// Slot state, scan pointer, victim search and result formation.
// ---------------------------------------------------------------------------
module pbc_datapath
	import pbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_item,
	input  wire pbc_cmd_t  cmd,
	output pbc_stat_t      stat,
	output out_item_t      res
);

	logic [31:0] tag_volume_q [NUM_SLOTS];
	logic [31:0] tag_vnode_q  [NUM_SLOTS];
	logic [31:0] tag_unique_q [NUM_SLOTS];
	logic [15:0] tag_page_q   [NUM_SLOTS];
	logic [31:0] stamp_q      [NUM_SLOTS];
	logic [7:0]  lock_q       [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q, dirty_q;
	logic [31:0] clock_q;

	in_item_t        it_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] nwb_q;
	logic [CNT_W-1:0] tot_q;
	logic [SLOT_W-1:0] hit_q, cln_q, drt_q;
	logic hitf_q, fc_q, fd_q;

	logic [SLOT_W-1:0] idx;
	logic [SLOT_W-1:0] islot;
	logic fmatch, pmatch, in_rng, fl_cand, slot_op;

	assign idx    = ptr_q[SLOT_W-1:0];
	assign islot  = it_q.slot[SLOT_W-1:0];
	assign in_rng = ({2'b00, it_q.slot} < 7'(NUM_SLOTS));
	assign slot_op = (it_q.operation == OP_REL) || (it_q.operation == OP_FAIL);
	assign fmatch = valid_q[idx] && tag_volume_q[idx] == it_q.fid_volume &&
		tag_vnode_q[idx] == it_q.fid_vnode && tag_unique_q[idx] == it_q.fid_unique;
	assign pmatch = fmatch && tag_page_q[idx] == it_q.page;
	assign fl_cand = dirty_q[idx] && (it_q.operation == OP_FLUSHA ||
		(it_q.operation == OP_FLUSHE && fmatch));

	assign stat.scan_end   = (ptr_q == CNT_W'(NUM_SLOTS - 1));
	assign stat.hit_found  = hitf_q;
	assign stat.flush_hit  = fl_cand;
	assign stat.flush_none = (tot_q == '0);
	assign stat.flush_last = ((nwb_q + CNT_W'(1)) == tot_q);

	logic [SLOT_W-1:0] vic;
	assign vic = fc_q ? cln_q : drt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			clock_q <= '0;
			it_q    <= '0;
			ptr_q   <= '0;
			nwb_q   <= '0;
			tot_q   <= '0;
			hit_q   <= '0;
			cln_q   <= '0;
			drt_q   <= '0;
			hitf_q  <= 1'b0;
			fc_q    <= 1'b0;
			fd_q    <= 1'b0;
			res     <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tag_volume_q[i] <= '0;
				tag_vnode_q[i]  <= '0;
				tag_unique_q[i] <= '0;
				tag_page_q[i]   <= '0;
				stamp_q[i]      <= '0;
				lock_q[i]       <= '0;
			end
		end else begin
			if (cmd.load) begin
				it_q <= in_item;
			end
			if (cmd.scan_clr) begin
				ptr_q  <= '0;
				nwb_q  <= '0;
				tot_q  <= '0;
				hitf_q <= 1'b0;
				fc_q   <= 1'b0;
				fd_q   <= 1'b0;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end
			if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
				if (!hitf_q && pmatch && it_q.operation == OP_READ) begin
					hitf_q <= 1'b1;
					hit_q  <= idx;
				end
				if (fl_cand && tot_q < CNT_W'(MAX_RESULTS)) begin
					tot_q <= tot_q + 1'b1;
				end
				if (lock_q[idx] == '0) begin
					if (dirty_q[idx]) begin
						if (!fd_q || stamp_q[idx] < stamp_q[drt_q]) begin
							fd_q  <= 1'b1;
							drt_q <= idx;
						end
					end else if (!fc_q || stamp_q[idx] < stamp_q[cln_q]) begin
						fc_q  <= 1'b1;
						cln_q <= idx;
					end
				end
				if (it_q.operation == OP_ZAP && fmatch) begin
					valid_q[idx] <= 1'b0;
					dirty_q[idx] <= 1'b0;
				end
			end
			if (cmd.do_flush) begin
				ptr_q <= ptr_q + 1'b1;
				if (fl_cand) begin
					nwb_q <= nwb_q + 1'b1;
					dirty_q[idx] <= 1'b0;
					res <= '{status: ST_FLUSH, slot_out: 5'(idx), writeback: 1'b1,
						wb_volume: tag_volume_q[idx], wb_vnode: tag_vnode_q[idx],
						wb_unique: tag_unique_q[idx], wb_page: tag_page_q[idx],
						last: 1'b0};
				end
			end
			if (cmd.do_hit) begin
				if (lock_q[hit_q] != LOCK_MAX) lock_q[hit_q] <= lock_q[hit_q] + 1'b1;
				clock_q <= clock_q + 1'b1;
				stamp_q[hit_q] <= clock_q + 1'b1;
				res <= '{status: ST_HIT, slot_out: 5'(hit_q), writeback: 1'b0,
					wb_volume: '0, wb_vnode: '0, wb_unique: '0, wb_page: '0, last: 1'b1};
			end
			if (cmd.do_alloc) begin
				if (!fc_q && !fd_q) begin
					res <= '{status: ST_LOCKED, slot_out: '0, writeback: 1'b0,
						wb_volume: '0, wb_vnode: '0, wb_unique: '0, wb_page: '0,
						last: 1'b1};
				end else begin
					res.status    <= (it_q.operation == OP_READ) ? ST_MISS : ST_NEW;
					res.slot_out  <= 5'(vic);
					res.writeback <= !fc_q;
					res.wb_volume <= fc_q ? '0 : tag_volume_q[vic];
					res.wb_vnode  <= fc_q ? '0 : tag_vnode_q[vic];
					res.wb_unique <= fc_q ? '0 : tag_unique_q[vic];
					res.wb_page   <= fc_q ? '0 : tag_page_q[vic];
					res.last      <= 1'b1;
					dirty_q[vic]  <= 1'b0;
					valid_q[vic]  <= 1'b1;
					tag_volume_q[vic] <= it_q.fid_volume;
					tag_vnode_q[vic]  <= it_q.fid_vnode;
					tag_unique_q[vic] <= it_q.fid_unique;
					tag_page_q[vic]   <= it_q.page;
					clock_q <= clock_q + 1'b1;
					stamp_q[vic] <= clock_q + 1'b1;
					if (lock_q[vic] != LOCK_MAX) lock_q[vic] <= lock_q[vic] + 1'b1;
				end
			end
			if (cmd.do_simple) begin
				res <= '{status: ST_DONE, slot_out: (slot_op ? it_q.slot : 5'd0),
					writeback: 1'b0, wb_volume: '0, wb_vnode: '0, wb_unique: '0,
					wb_page: '0, last: 1'b1};
				if (slot_op && in_rng) begin
					if (lock_q[islot] != '0) lock_q[islot] <= lock_q[islot] - 1'b1;
					if (it_q.operation == OP_REL) begin
						if (it_q.modified && valid_q[islot]) dirty_q[islot] <= 1'b1;
					end else begin
						valid_q[islot] <= 1'b0;
						dirty_q[islot] <= 1'b0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pbc_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pbc_ctrl
// Sequencer: accept, scan slots, emit results, hold on stall.
// ---------------------------------------------------------------------------
module pbc_ctrl
	import pbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire op_t       op,
	input  wire pbc_stat_t stat,
	input  wire logic      out_stall,
	output logic           in_stall,
	output logic           out_valid,
	output pbc_cmd_t       cmd,
	output logic           res_last
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_FLUSH, S_OUT, S_FOUT} state_t;
	state_t state_q;
	logic   fl_end_q;

	logic is_flush;
	assign is_flush = (op == OP_FLUSHE) || (op == OP_FLUSHA);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT) || (state_q == S_FOUT);
	assign res_last  = (state_q == S_OUT) || fl_end_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load     = in_valid;
				cmd.scan_clr = in_valid;
			end
			S_SCAN:   cmd.scan_step = 1'b1;
			S_DECIDE: begin
				priority if (op == OP_READ && stat.hit_found) cmd.do_hit = 1'b1;
				else if (op == OP_READ || op == OP_NEW) cmd.do_alloc = 1'b1;
				else if (is_flush) begin
					cmd.do_simple = stat.flush_none;
					cmd.ptr_clr   = !stat.flush_none;
				end
				else cmd.do_simple = 1'b1;
			end
			S_FLUSH:  cmd.do_flush = 1'b1;
			S_OUT, S_FOUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fl_end_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					fl_end_q <= 1'b0;
					state_q  <= (op == OP_REL || op == OP_FAIL || op == OP_NONE) ?
						S_DECIDE : S_SCAN;
				end
				S_SCAN: if (stat.scan_end) state_q <= S_DECIDE;
				S_DECIDE: state_q <= (is_flush && !stat.flush_none) ? S_FLUSH : S_OUT;
				S_FLUSH: begin
					if (stat.flush_hit) begin
						fl_end_q <= stat.flush_last;
						state_q  <= S_FOUT;
					end else if (stat.scan_end) begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				S_FOUT: if (!out_stall) state_q <= fl_end_q ? S_IDLE : S_FLUSH;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/page_buffer_cache_policy_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// page_buffer_cache_policy_core
// Page slot tag, lock and LRU policy with clean-first eviction.
//
// Input channel in_valid/in_stall carries one request item; output channel
// out_valid/out_stall carries result items, last marking the final one.
// Reads, new, zap: a scan of the slots and a decide step, then one
// result. Release, fill failed and the unused code skip the scan: a decide
// step, then one result. Flushes scan the slots once to count the
// writebacks, then walk them again one a cycle and present each writeback
// until taken, the walk holding meanwhile; a flush with nothing to write
// back gives one done result after its scan. One item is in work at a time;
// in_stall is high until its results are delivered. A stalled result holds.
// Reset clears all slots, lock counts, stamps and the sequencer.
// ---------------------------------------------------------------------------
module page_buffer_cache_policy_core
	import pbc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_item_t     out_data
);

	pbc_cmd_t  cmd;
	pbc_stat_t stat;
	out_item_t res;
	in_item_t  it_q;
	logic      res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (cmd.load) begin
			it_q <= in_data;
		end
	end

	pbc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid,
		.op        (op_t'(cmd.load ? in_data.operation : it_q.operation)),
		.stat, .out_stall, .in_stall, .out_valid, .cmd, .res_last
	);

	pbc_datapath u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .stat, .res
	);

	always_comb begin
		out_data      = res;
		out_data.last = res_last;
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");
	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.writeback) |-> (out_data.wb_page == '0))
		else $error("writeback tag not cleared");
	a_flush_st: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_FLUSH) |-> out_data.writeback)
		else $error("flush without writeback");
`endif

endmodule
`default_nettype wire
